// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port-level checker in fcf_sva.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset
`define FCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define FCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches the reset cycles
`define FCF_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fcf_pkg.sv -----
// Types, constants and tables of the flow pair consistency filter
package fcf_pkg;

  localparam int unsigned DATA_W        = 16;
  localparam int unsigned FRAC_BITS_DEF = 5;
  localparam int unsigned CFG_W         = 15;
  localparam int unsigned ANG_LIM_RST   = 640;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned SQ_W          = 2 * DATA_W - 1;
  localparam int unsigned LEN_W         = SQ_W + 1;
  localparam int unsigned LIM_W         = 2 * CFG_W;

  localparam int unsigned CW            = 20;
  localparam int unsigned ZW            = 24;
  localparam int unsigned AT_W          = 20;
  localparam int unsigned CORDIC_STEPS  = 16;
  localparam int unsigned STEP_W        = $clog2(CORDIC_STEPS);
  localparam int unsigned STEPS_PER_STG = 2;
  localparam int unsigned CORDIC_STGS   = CORDIC_STEPS / STEPS_PER_STG;
  localparam int unsigned DEG_SHIFT     = 14;
  localparam int unsigned ROUND_SHIFT   = 8;
  localparam int unsigned ANG_W         = ZW - ROUND_SHIFT;

  localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 << DEG_SHIFT);
  localparam logic signed [ZW-1:0] Z_FULL_TURN = ZW'(360 << DEG_SHIFT);
  localparam logic signed [ZW-1:0] Z_ROUND     = ZW'(1 << (ROUND_SHIFT - 1));
  localparam logic [ANG_W-1:0]     ANG_FULL    = ANG_W'(23040);

  localparam logic [AT_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    AT_W'(737280), AT_W'(435242), AT_W'(229970), AT_W'(116736),
    AT_W'(58595),  AT_W'(29326),  AT_W'(14667),  AT_W'(7334),
    AT_W'(3667),   AT_W'(1833),   AT_W'(917),    AT_W'(458),
    AT_W'(229),    AT_W'(115),    AT_W'(57),     AT_W'(29)
  };

  // Register select, taken from paddr[2]
  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_ANG_LIM = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
  } vec_t;

  typedef struct packed {
    vec_t first;
    vec_t second;
  } pair_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    pair_t vecs;
    lane_t a;
    lane_t b;
    logic  dir_en;
  } work_t;

endpackage

// ----- rtl/core/fcf_if.sv -----
// Stream channel interfaces for flow pairs in and cleaned pairs out
interface fcf_in_if;
  import fcf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] first_dx;
  logic signed [DATA_W-1:0] first_dy;
  logic signed [DATA_W-1:0] second_dx;
  logic signed [DATA_W-1:0] second_dy;

  modport source (output valid, first_dx, first_dy, second_dx, second_dy, input ready);
  modport sink   (input valid, first_dx, first_dy, second_dx, second_dy, output ready);
endinterface

interface fcf_out_if;
  import fcf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_first_dx;
  logic signed [DATA_W-1:0] out_first_dy;
  logic signed [DATA_W-1:0] out_second_dx;
  logic signed [DATA_W-1:0] out_second_dy;

  modport source (output valid, out_first_dx, out_first_dy, out_second_dx, out_second_dy,
                  input ready);
  modport sink   (input valid, out_first_dx, out_first_dy, out_second_dx, out_second_dy,
                  output ready);
endinterface

// ----- rtl/core/fcf_cfg.sv -----
// APB register file: minimum length and angle limit, squared limit
module fcf_cfg #(
  parameter int unsigned FRAC_BITS = fcf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcf_pkg::APB_AW-1:0] paddr,
  input  logic [fcf_pkg::APB_DW-1:0] pwdata,
  output logic [fcf_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [fcf_pkg::LIM_W-1:0]  lim,
  output logic [fcf_pkg::CFG_W-1:0]  ang_lim
);
  import fcf_pkg::*;

  localparam logic [CFG_W-1:0] MIN_LEN_RST = CFG_W'(1 << FRAC_BITS);
  localparam logic [LIM_W-1:0] LIM_RST     = LIM_W'((1 << FRAC_BITS) * (1 << FRAC_BITS));

  logic [CFG_W-1:0] min_len_r;
  logic [CFG_W-1:0] ang_lim_r;
  logic [LIM_W-1:0] lim_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      ang_lim_r <= CFG_W'(ANG_LIM_RST);
      lim_r     <= LIM_RST;
    end else begin
      lim_r <= LIM_W'(min_len_r) * LIM_W'(min_len_r);
      if (wr_en) begin
        case (paddr[2])
          REG_MIN_LEN: min_len_r <= pwdata[CFG_W-1:0];
          REG_ANG_LIM: ang_lim_r <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_LEN: prdata = APB_DW'(min_len_r);
      REG_ANG_LIM: prdata = APB_DW'(ang_lim_r);
      default:     prdata = '0;
    endcase
  end

  assign lim     = lim_r;
  assign ang_lim = ang_lim_r;

endmodule

// ----- rtl/core/fcf_check.sv -----
// Length stages: squares, sums, length tests and CORDIC lane set-up
module fcf_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fcf_pkg::LIM_W-1:0] lim,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  fcf_pkg::pair_t            s_data,
  output logic                      m_valid,
  input  logic                      m_ready,
  output fcf_pkg::work_t            m_data
);
  import fcf_pkg::*;

  function automatic logic [SQ_W-1:0] square(input logic signed [DATA_W-1:0] v);
    logic signed [2*DATA_W-1:0] p;
    p = v * v;
    return p[SQ_W-1:0];
  endfunction

  function automatic lane_t lane_init(input vec_t v, input logic drop);
    lane_t l;
    l.zero = drop || (v.dx == '0 && v.dy == '0);
    if (v.dx[DATA_W-1]) begin
      l.x = -CW'(v.dx);
      l.y = -CW'(v.dy);
      l.z = Z_HALF_TURN;
    end else begin
      l.x = CW'(v.dx);
      l.y = CW'(v.dy);
      l.z = '0;
    end
    return l;
  endfunction

  logic             a_v_r, b_v_r, c_v_r;
  logic             en_a, en_b, en_c;
  pair_t            a_pair_r, b_pair_r;
  logic [SQ_W-1:0]  a_sq_ax_r, a_sq_ay_r, a_sq_bx_r, a_sq_by_r;
  logic [LEN_W-1:0] b_la_r, b_lb_r;
  logic [LEN_W-1:0] lim_ext;
  logic             a_short, b_short, a_drop;
  work_t            c_work_nxt, c_work_r;

  assign en_c    = !c_v_r || m_ready;
  assign en_b    = !b_v_r || en_c;
  assign en_a    = !a_v_r || en_b;
  assign s_ready = en_a;

  always_comb begin
    lim_ext  = LEN_W'(lim);
    a_short  = b_la_r < lim_ext;
    b_short  = b_lb_r < lim_ext;
    a_drop   = a_short || ({b_la_r, 2'b00} < {2'b00, b_lb_r}) || (b_la_r > b_lb_r);
    c_work_nxt.vecs = b_pair_r;
    if (a_drop) begin
      c_work_nxt.vecs.first = '0;
    end
    if (b_short) begin
      c_work_nxt.vecs.second = '0;
    end
    c_work_nxt.a      = lane_init(b_pair_r.first, a_drop);
    c_work_nxt.b      = lane_init(b_pair_r.second, b_short);
    c_work_nxt.dir_en = !a_short || !b_short;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= s_valid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_pair_r  <= s_data;
      a_sq_ax_r <= square(s_data.first.dx);
      a_sq_ay_r <= square(s_data.first.dy);
      a_sq_bx_r <= square(s_data.second.dx);
      a_sq_by_r <= square(s_data.second.dy);
    end
    if (en_b) begin
      b_pair_r <= a_pair_r;
      b_la_r   <= LEN_W'(a_sq_ax_r) + LEN_W'(a_sq_ay_r);
      b_lb_r   <= LEN_W'(a_sq_bx_r) + LEN_W'(a_sq_by_r);
    end
    if (en_c) begin
      c_work_r <= c_work_nxt;
    end
  end

  assign m_valid = c_v_r;
  assign m_data  = c_work_r;

endmodule

// ----- rtl/core/fcf_cordic.sv -----
// Pipelined CORDIC vectoring for both lanes, two iterations per stage
module fcf_cordic (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s_valid,
  output logic           s_ready,
  input  fcf_pkg::work_t s_data,
  output logic           m_valid,
  input  logic           m_ready,
  output fcf_pkg::work_t m_data
);
  import fcf_pkg::*;

  function automatic lane_t rot(input lane_t s, input logic [STEP_W-1:0] i);
    lane_t                r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] ang;
    r   = s;
    xs  = s.x >>> i;
    ys  = s.y >>> i;
    ang = ZW'(ATAN_TAB[i]);
    if (!s.y[CW-1] && s.y != '0) begin
      r.x = s.x + ys;
      r.y = s.y - xs;
      r.z = s.z + ang;
    end else begin
      r.x = s.x - ys;
      r.y = s.y + xs;
      r.z = s.z - ang;
    end
    return r;
  endfunction

  work_t                  stg_r   [CORDIC_STGS];
  work_t                  stg_nxt [CORDIC_STGS];
  logic [CORDIC_STGS-1:0] v_r;
  logic [CORDIC_STGS-1:0] en;

  always_comb begin
    en[CORDIC_STGS-1] = !v_r[CORDIC_STGS-1] || m_ready;
    for (int g = CORDIC_STGS - 2; g >= 0; g--) begin
      en[g] = !v_r[g] || en[g+1];
    end
  end

  always_comb begin
    for (int g = 0; g < CORDIC_STGS; g++) begin
      stg_nxt[g] = (g == 0) ? s_data : stg_r[(g == 0) ? 0 : g - 1];
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        stg_nxt[g].a = rot(stg_nxt[g].a, STEP_W'(g * STEPS_PER_STG + k));
        stg_nxt[g].b = rot(stg_nxt[g].b, STEP_W'(g * STEPS_PER_STG + k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int g = 0; g < CORDIC_STGS; g++) begin
        if (en[g]) v_r[g] <= (g == 0) ? s_valid : v_r[(g == 0) ? 0 : g - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < CORDIC_STGS; g++) begin
      if (en[g]) stg_r[g] <= stg_nxt[g];
    end
  end

  assign s_ready = en[0];
  assign m_valid = v_r[CORDIC_STGS-1];
  assign m_data  = stg_r[CORDIC_STGS-1];

endmodule

// ----- rtl/core/fcf_decide.sv -----
// Angle rounding, direction comparison and the output register
module fcf_decide (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fcf_pkg::CFG_W-1:0] ang_lim,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  fcf_pkg::work_t            s_data,
  output logic                      m_valid,
  input  logic                      m_ready,
  output fcf_pkg::pair_t            m_data
);
  import fcf_pkg::*;

  function automatic logic [CFG_W-1:0] angle(input lane_t l);
    logic signed [ZW-1:0] zz;
    logic signed [ZW-1:0] sum;
    logic [ANG_W-1:0]     r;
    zz  = l.z[ZW-1] ? l.z + Z_FULL_TURN : l.z;
    sum = zz + Z_ROUND;
    r   = sum[ZW-1:ROUND_SHIFT];
    if (r >= ANG_FULL) begin
      r = r - ANG_FULL;
    end
    return l.zero ? '0 : r[CFG_W-1:0];
  endfunction

  logic               d_v_r, e_v_r;
  logic               en_d, en_e;
  pair_t              d_vecs_r, e_vecs_r, e_vecs_nxt;
  logic               d_dir_en_r;
  logic [CFG_W-1:0]   d_ang_a_r, d_ang_b_r;
  logic signed [CFG_W:0] diff;
  logic [CFG_W-1:0]   diff_abs;

  assign en_e    = !e_v_r || m_ready;
  assign en_d    = !d_v_r || en_e;
  assign s_ready = en_d;

  always_comb begin
    diff       = $signed({1'b0, d_ang_a_r}) - $signed({1'b0, d_ang_b_r});
    diff_abs   = diff[CFG_W] ? CFG_W'(-diff) : diff[CFG_W-1:0];
    e_vecs_nxt = d_vecs_r;
    if (d_dir_en_r && diff_abs > ang_lim) begin
      e_vecs_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (en_d) d_v_r <= s_valid;
      if (en_e) e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_vecs_r   <= s_data.vecs;
      d_dir_en_r <= s_data.dir_en;
      d_ang_a_r  <= angle(s_data.a);
      d_ang_b_r  <= angle(s_data.b);
    end
    if (en_e) begin
      e_vecs_r <= e_vecs_nxt;
    end
  end

  assign m_valid = e_v_r;
  assign m_data  = e_vecs_r;

endmodule

// ----- rtl/core/flow_pair_consistency_filter.sv -----
// Top level of the flow pair consistency filter
//
//   channel   direction  transfer
//   in_chan   sink       first/second flow vector of one pixel
//   out_chan  source     both vectors, each zeroed if rejected
//   apb       slave      min_length at 0x0, angle_limit at 0x4
//
// One pair a cycle while out_chan is not stalled; from input transfer to output valid:
// three length stages, eight CORDIC stages of two iterations, two decision stages.
// Every stage holds its own valid bit and moves on when the next stage is empty or moving.
// in_chan.ready drops only when all stages are full and out_chan is stalled.
// Reset empties the pipeline and loads min_length = 1 << FRAC_BITS, angle_limit = 640.
module flow_pair_consistency_filter #(
  parameter int unsigned FRAC_BITS = fcf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fcf_in_if.sink                     in_chan,
  fcf_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcf_pkg::APB_AW-1:0] paddr,
  input  logic [fcf_pkg::APB_DW-1:0] pwdata,
  output logic [fcf_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import fcf_pkg::*;

  logic [LIM_W-1:0] lim;
  logic [CFG_W-1:0] ang_lim;
  pair_t            in_pair;
  logic             chk_valid, chk_ready;
  work_t            chk_data;
  logic             cor_valid, cor_ready;
  work_t            cor_data;
  pair_t            dec_data;

  assign in_pair.first.dx  = in_chan.first_dx;
  assign in_pair.first.dy  = in_chan.first_dy;
  assign in_pair.second.dx = in_chan.second_dx;
  assign in_pair.second.dy = in_chan.second_dy;

  fcf_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lim     (lim),
    .ang_lim (ang_lim)
  );

  fcf_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .lim     (lim),
    .s_valid (in_chan.valid),
    .s_ready (in_chan.ready),
    .s_data  (in_pair),
    .m_valid (chk_valid),
    .m_ready (chk_ready),
    .m_data  (chk_data)
  );

  fcf_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (chk_valid),
    .s_ready (chk_ready),
    .s_data  (chk_data),
    .m_valid (cor_valid),
    .m_ready (cor_ready),
    .m_data  (cor_data)
  );

  fcf_decide u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .ang_lim (ang_lim),
    .s_valid (cor_valid),
    .s_ready (cor_ready),
    .s_data  (cor_data),
    .m_valid (out_chan.valid),
    .m_ready (out_chan.ready),
    .m_data  (dec_data)
  );

  assign out_chan.out_first_dx  = dec_data.first.dx;
  assign out_chan.out_first_dy  = dec_data.first.dy;
  assign out_chan.out_second_dx = dec_data.second.dx;
  assign out_chan.out_second_dy = dec_data.second.dy;

endmodule

// ----- rtl/core/fcf_sva.sv -----
// Port-level checker for the flow pair consistency filter, with its bind
`include "assert_macros.svh"

module fcf_sva (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [fcf_pkg::DATA_W-1:0] out_first_dx,
  input logic signed [fcf_pkg::DATA_W-1:0] out_first_dy,
  input logic signed [fcf_pkg::DATA_W-1:0] out_second_dx,
  input logic signed [fcf_pkg::DATA_W-1:0] out_second_dy
);
  import fcf_pkg::*;

  `FCF_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid after reset")

  `FCF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_first_dx, out_first_dy, out_second_dx, out_second_dy}), "stalled result changed")

  `FCF_ASSERT_IMP(a_in_ready, !out_valid || out_ready, in_ready, "input blocked while output drains")

  `FCF_ASSERT_IMP(a_pair_keep, out_valid && (out_first_dx != '0 || out_first_dy != '0), out_second_dx != '0 || out_second_dy != '0, "first kept without second")

endmodule

bind flow_pair_consistency_filter fcf_sva u_fcf_sva (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_first_dx  (out_chan.out_first_dx),
  .out_first_dy  (out_chan.out_first_dy),
  .out_second_dx (out_chan.out_second_dx),
  .out_second_dy (out_chan.out_second_dy)
);

// ----- sim/tb_flow_pair_consistency_filter.sv -----
// Self-checking testbench of the flow pair consistency filter: directed and random flow pairs
module tb_flow_pair_consistency_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import fcf_pkg::*;

  localparam logic [APB_AW-1:0] ADDR_MIN_LEN = {REG_MIN_LEN, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_ANG_LIM = {REG_ANG_LIM, 2'b00};
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 80;
  localparam int SETTLE      = 20;
  localparam longint ATAN_STEP_DEG [16] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29
  };

  class flow_pair_scoreboard;
    logic [CFG_W-1:0] min_len;
    logic [CFG_W-1:0] ang_lim;
    pair_t cleaned_q[$];
    int errors;

    function new();
      min_len = 15'd32;
      ang_lim = 15'd640;
      errors  = 0;
    endfunction

    function longint heading(longint x, longint y);
      longint z, base, xs, ys;
      z = 0;
      base = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        base = 180 <<< 14;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP_DEG[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP_DEG[i];
        end
      end
      z = z + base;
      if (z < 0) z = z + (360 <<< 14);
      z = (z + 128) >>> 8;
      if (z >= 23040) z = z - 23040;
      return z;
    endfunction

    function pair_t clean_pair(pair_t p);
      longint ax, ay, bx, by, la, lb, lim, diff;
      bit drop_a, drop_b;
      pair_t r;
      ax = p.first.dx;
      ay = p.first.dy;
      bx = p.second.dx;
      by = p.second.dy;
      la = ax * ax + ay * ay;
      lb = bx * bx + by * by;
      lim = longint'(min_len) * longint'(min_len);
      drop_a = (la < lim) || (4 * la < lb) || (la > lb);
      drop_b = (lb < lim);
      if (drop_a) begin
        ax = 0;
        ay = 0;
      end
      if (drop_b) begin
        bx = 0;
        by = 0;
      end
      if (la >= lim || lb >= lim) begin
        diff = heading(ax, ay) - heading(bx, by);
        if (diff < 0) diff = -diff;
        if (diff > longint'(ang_lim)) begin
          ax = 0;
          ay = 0;
          bx = 0;
          by = 0;
        end
      end
      r.first.dx  = 16'(ax);
      r.first.dy  = 16'(ay);
      r.second.dx = 16'(bx);
      r.second.dy = 16'(by);
      return r;
    endfunction

    function void note_pair(pair_t p);
      cleaned_q.insert(cleaned_q.size(), clean_pair(p));
    endfunction

    function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                logic signed [DATA_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pair(pair_t got);
      pair_t want;
      if (cleaned_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: expected none, actual %0d %0d %0d %0d", $time,
                 got.first.dx, got.first.dy, got.second.dx, got.second.dy);
        return;
      end
      want = cleaned_q.pop_front();
      compare_field("out_first_dx", want.first.dx, got.first.dx);
      compare_field("out_first_dy", want.first.dy, got.first.dy);
      compare_field("out_second_dx", want.second.dx, got.second.dx);
      compare_field("out_second_dy", want.second.dy, got.second.dy);
    endfunction

    function int pending();
      return cleaned_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  fcf_in_if  in_bus ();
  fcf_out_if out_bus ();

  flow_pair_consistency_filter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  flow_pair_scoreboard sb = new();

  int src_pct  = 30;
  int sink_pct = 30;
  int sink_gap_left = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  int stall_count = 0;

  always #2 clk = ~clk;

  function automatic pair_t make_pair(int ax, int ay, int bx, int by);
    pair_t p;
    p.first.dx  = 16'(ax);
    p.first.dy  = 16'(ay);
    p.second.dx = 16'(bx);
    p.second.dy = 16'(by);
    return p;
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_comp(int w);
    int r;
    r = $urandom;
    return r >>> (31 - w);
  endfunction

  function automatic pair_t random_pair();
    int w, bx, by, ax, ay, k, kind;
    w = $urandom_range(0, 15);
    bx = rand_comp(w);
    by = rand_comp(w);
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      k = $urandom_range(6, 18);
      ax = sat16(((bx * k) >>> 4) + int'($urandom_range(0, 6)) - 3);
      ay = sat16(((by * k) >>> 4) + int'($urandom_range(0, 6)) - 3);
    end else if (kind <= 7) begin
      ax = int'(16'($urandom)) - ($urandom_range(0, 1) ? 0 : 0);
      ax = $signed(16'($urandom));
      ay = $signed(16'($urandom));
      bx = $signed(16'($urandom));
      by = $signed(16'($urandom));
    end else begin
      ax = rand_comp(w);
      ay = rand_comp(w);
    end
    return make_pair(ax, ay, bx, by);
  endfunction

  // Sink side: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (sink_gap_left > 0) begin
        sink_gap_left--;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(1, 100) <= sink_pct) begin
        sink_gap_left = $urandom_range(0, 10);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_pair(make_pair(in_bus.first_dx, in_bus.first_dy,
                               in_bus.second_dx, in_bus.second_dy));
      if (out_bus.valid && out_bus.ready)
        sb.check_pair(make_pair(out_bus.out_first_dx, out_bus.out_first_dy,
                                out_bus.out_second_dx, out_bus.out_second_dy));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send_pair(pair_t p);
    in_bus.valid     <= 1'b1;
    in_bus.first_dx  <= p.first.dx;
    in_bus.first_dy  <= p.first.dy;
    in_bus.second_dx <= p.second.dx;
    in_bus.second_dy <= p.second.dy;
    do @(posedge clk); while (!in_bus.ready);
    if ($urandom_range(1, 100) <= src_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic cfg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(logic [APB_DW-1:0] min_word, logic [APB_DW-1:0] ang_word,
                           int count, int src_idle, int sink_idle, bit long_hold);
    in_bus.valid <= 1'b0;
    drain();
    cfg_write(ADDR_MIN_LEN, min_word);
    cfg_write(ADDR_ANG_LIM, ang_word);
    sb.min_len = min_word[CFG_W-1:0];
    sb.ang_lim = ang_word[CFG_W-1:0];
    src_pct  = src_idle;
    sink_pct = sink_idle;
    if (long_hold) hold_request = 1'b1;
    repeat (count) send_pair(random_pair());
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.first_dx = '0;
    in_bus.first_dy = '0;
    in_bus.second_dx = '0;
    in_bus.second_dy = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_pair(make_pair(0, 0, 0, 0));
    send_pair(make_pair(32, 0, 32, 0));
    send_pair(make_pair(31, 0, 40, 0));
    send_pair(make_pair(-32768, -32768, -32768, -32768));
    send_pair(make_pair(32767, 32767, -32768, -32768));
    send_pair(make_pair(100, 0, 50, 0));
    send_pair(make_pair(40, 0, 100, 0));
    send_pair(make_pair(50, 0, 100, 0));
    send_pair(make_pair(0, 100, 10, 100));
    send_pair(make_pair(0, 100, 30, 100));
    send_pair(make_pair(-100, 0, -100, 1));
    send_pair(make_pair(100, -1, 100, 1));
    send_pair(make_pair(0, -32768, 0, 32767));
    send_pair(make_pair(1, 1, 32767, -32768));
    send_pair(make_pair(32767, 0, 32767, 0));
    send_pair(make_pair(-32768, 0, -32768, 0));
    send_pair(make_pair(0, 0, 100, 100));
    send_pair(make_pair(22, 23, 23, 22));
    send_pair(make_pair(-1, -1, 0, 1));
    send_pair(make_pair('h5555, 'hAAAA, 'h5555, 'hAAAA));
    send_pair(make_pair('hAAAA, 'h5555, 'hAAAA, 'h5555));
    repeat (150) send_pair(random_pair());

    run_phase(32'd0, 32'd0, 200, 20, 40, 1'b0);
    run_phase(32'd32767, 32'd32767, 150, 30, 20, 1'b0);
    run_phase(32'd1, 32'd23040, 200, 0, 10, 1'b1);
    run_phase(32'd200, 32'd23041, 150, 40, 30, 1'b0);
    run_phase(32'hFFFF_8020, 32'd1280, 250, 25, 0, 1'b0);
    run_phase(32'd64, 32'd320, 250, 15, 25, 1'b0);
    run_phase(32'd16, 32'd640, 200, 0, 0, 1'b0);

    in_bus.valid <= 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
